### src/quaternion_vector_transform_unit_assert.svh
// ----------------------------------------------------------------------------
// Quaternion vector transform assertion macros
// Shared concurrent assertion forms for the transform unit.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_TRANSFORM_UNIT_ASSERT_SVH
`define QUATERNION_VECTOR_TRANSFORM_UNIT_ASSERT_SVH

// same-cycle implication
`define QVT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qvt check failed");

// next-cycle implication
`define QVT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qvt check failed");

`endif

### src/qvt_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion vector transform package
// Widths, register codes, shared types and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package qvt_pkg;

    localparam int CW_IDX = 3;
    localparam logic [CW_IDX-1:0] REG_ROT  = 3'd0;
    localparam logic [CW_IDX-1:0] REG_SX   = 3'd1;
    localparam logic [CW_IDX-1:0] REG_SY   = 3'd2;
    localparam logic [CW_IDX-1:0] REG_SZ   = 3'd3;
    localparam logic [CW_IDX-1:0] REG_TX   = 3'd4;
    localparam logic [CW_IDX-1:0] REG_TY   = 3'd5;
    localparam logic [CW_IDX-1:0] REG_TZ   = 3'd6;

    localparam int DW  = 24;          // coordinate width
    localparam int SW  = 16;          // scale width
    localparam int QW  = 17;          // quaternion component, room for negation
    localparam int VW  = 34;          // vector into rotation
    localparam int PW  = QW + VW;     // first cross products
    localparam int CPW = PW + 1;      // first cross sums
    localparam int TW  = CPW - 13;    // doubled cross term
    localparam int P2W = QW + TW;     // second products
    localparam int UW  = P2W + 2;     // second sums
    localparam int RW  = UW - 14;     // rotation delta
    localparam int V2W = RW + 1;      // rotated vector
    localparam int OW  = V2W + 1;     // after translation
    localparam int NW  = V2W + 9;     // division numerator
    localparam int QTW = DW;          // quotient bits
    localparam int NDIV = QTW;        // divider stages
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    localparam logic signed [OW-1:0] SAT_MAX = OW'(64'sd8388607);
    localparam logic signed [OW-1:0] SAT_MIN = OW'(-64'sd8388608);
    localparam logic signed [OW-1:0] DIV_OVF = OW'(64'sd16777216);

    typedef struct packed {
        logic inv;
        logic skip;
        logic pos;
    } t_mode;

    typedef struct packed {
        t_mode                  mode;
        logic signed [VW-1:0]   vx;
        logic signed [VW-1:0]   vy;
        logic signed [VW-1:0]   vz;
    } t_item;

    typedef struct packed {
        logic [63:0]            rot;
        logic [2:0][SW-1:0]     scale;
        logic [2:0][DW-1:0]     tr;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic signed [QW-1:0] q_comp(t_cfg c, logic inv, int idx);
        logic signed [QW-1:0] e;
        e = QW'($signed(c.rot[16*idx +: 16]));
        return inv ? -e : e;
    endfunction

endpackage

`default_nettype wire

### src/qvt_front.sv
// ----------------------------------------------------------------------------
// Quaternion vector transform front end
// Accepts requests, applies forward scaling or inverse translation, queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module qvt_front import qvt_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [2:0]           i_req_type,
    input  wire logic signed [DW-1:0] i_vec_x,
    input  wire logic signed [DW-1:0] i_vec_y,
    input  wire logic signed [DW-1:0] i_vec_z,
    input  wire t_cfg                 i_cfg,
    input  wire t_qstat               i_qstat,
    output logic                      o_push,
    output t_item                     o_item
);

    logic                   r_vld;
    t_mode                  r_mode;
    logic signed [DW-1:0]   r_v [3];
    logic signed [VW-1:0]   w_o [3];
    logic                   w_acc;

    assign o_stall = r_vld && i_qstat.full;
    assign o_push  = r_vld && !i_qstat.full;
    assign w_acc   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_acc) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
        if (w_acc) begin
            r_mode <= t_mode'(i_req_type);
            r_v[0] <= i_vec_x;
            r_v[1] <= i_vec_y;
            r_v[2] <= i_vec_z;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_mode.inv) begin
                w_o[i] = r_mode.pos ? VW'(r_v[i]) - VW'($signed(i_cfg.tr[i])) : VW'(r_v[i]);
            end else if (!r_mode.skip) begin
                w_o[i] = VW'(((42)'(r_v[i]) * (42)'($signed({1'b0, i_cfg.scale[i]}))
                              + (42)'(128)) >>> 8);
            end else begin
                w_o[i] = VW'(r_v[i]);
            end
        end
        o_item.mode = r_mode;
        o_item.vx   = w_o[0];
        o_item.vy   = w_o[1];
        o_item.vz   = w_o[2];
    end

endmodule

`default_nettype wire

### src/qvt_queue.sv
// ----------------------------------------------------------------------------
// Quaternion vector transform queue
// Short FIFO between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module qvt_queue import qvt_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_item  i_item,
    input  wire logic   i_pop,
    output t_item       o_item,
    output t_qstat      o_stat
);

    t_item              r_mem [QDEPTH];
    logic [QAW-1:0]     r_wr;
    logic [QAW-1:0]     r_rd;
    logic [QAW:0]       r_cnt;

    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_item       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

### src/qvt_back.sv
// ----------------------------------------------------------------------------
// Quaternion vector transform back end
// Rotation pipeline, translation, pipelined scale divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qvt_back import qvt_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire t_item          i_item,
    input  wire logic           i_item_vld,
    output logic                o_pop,
    input  wire t_cfg           i_cfg,
    input  wire logic           i_stall,
    output logic                o_valid,
    output logic signed [DW-1:0] o_res_x,
    output logic signed [DW-1:0] o_res_y,
    output logic signed [DW-1:0] o_res_z,
    output logic                o_saturated,
    output logic                o_zero_scale_error
);

    typedef struct packed {
        logic                       vld;
        logic                       dm;
        logic [2:0]                 zero;
        logic [2:0]                 early;
        logic [2:0]                 neg;
        logic [2:0][SW-1:0]         rem;
        logic [2:0][QTW-1:0]        low;
        logic [2:0][QTW-1:0]        quo;
        logic [2:0][OW-1:0]         val;
    } t_dstg;

    function automatic t_dstg div_step(t_dstg a, t_cfg c);
        t_dstg      b;
        logic [SW:0] x;
        logic       qb;
        b = a;
        for (int i = 0; i < 3; i++) begin
            x = {a.rem[i], a.low[i][QTW-1]};
            if (x >= {1'b0, c.scale[i]}) begin
                b.rem[i] = SW'(x - {1'b0, c.scale[i]});
                qb = 1'b1;
            end else begin
                b.rem[i] = x[SW-1:0];
                qb = 1'b0;
            end
            b.low[i] = {a.low[i][QTW-2:0], 1'b0};
            b.quo[i] = {a.quo[i][QTW-2:0], qb};
        end
        return b;
    endfunction

    logic                       w_en;
    logic signed [VW-1:0]       w_vin [3];
    logic signed [QW-1:0]       w_qa [3];
    logic signed [QW-1:0]       w_qc [3];
    logic signed [15:0]         w_w;

    logic                       r1_vld;
    t_mode                      r1_mode;
    logic signed [VW-1:0]       r1_v [3];
    logic signed [PW-1:0]       r1_p [6];

    logic                       r2_vld;
    t_mode                      r2_mode;
    logic signed [VW-1:0]       r2_v [3];
    logic signed [TW-1:0]       r2_t [3];

    logic                       r3_vld;
    t_mode                      r3_mode;
    logic signed [VW-1:0]       r3_v [3];
    logic signed [P2W-1:0]      r3_m [6];
    logic signed [P2W-1:0]      r3_wt [3];

    logic                       r4_vld;
    t_mode                      r4_mode;
    logic signed [V2W-1:0]      r4_v [3];

    t_dstg                      r_d [NDIV+1];
    t_dstg                      n_d0;

    logic                       r_out_vld;
    logic signed [DW-1:0]       r_res [3];
    logic                       r_sat;
    logic                       r_zerr;
    logic signed [OW-1:0]       w_fv [3];
    logic signed [DW-1:0]       n_res [3];
    logic                       n_sat;

    assign w_en  = !r_out_vld || !i_stall;
    assign o_pop = w_en && i_item_vld;
    assign w_w   = $signed(i_cfg.rot[63:48]);

    always_comb begin
        w_vin[0] = i_item.vx;
        w_vin[1] = i_item.vy;
        w_vin[2] = i_item.vz;
        for (int i = 0; i < 3; i++) begin
            w_qa[i] = q_comp(i_cfg, i_item.mode.inv, i);
            w_qc[i] = q_comp(i_cfg, r2_mode.inv, i);
        end
    end

    // divider entry: translation, numerator, overflow and zero-scale checks
    always_comb begin
        logic signed [OW-1:0]   v;
        logic [V2W-1:0]         mag;
        logic [NW-1:0]          num;
        logic [NW-1:0]          thr;
        n_d0     = '0;
        n_d0.vld = r4_vld;
        n_d0.dm  = r4_mode.inv && !r4_mode.skip;
        for (int i = 0; i < 3; i++) begin
            v = OW'(r4_v[i]);
            if (!r4_mode.inv && r4_mode.pos) begin
                v = v + OW'($signed(i_cfg.tr[i]));
            end
            mag = r4_v[i][V2W-1] ? V2W'(-r4_v[i]) : V2W'(r4_v[i]);
            num = {mag, 8'b0} + NW'(i_cfg.scale[i] >> 1);
            thr = (NW'(i_cfg.scale[i]) << 23) + NW'(i_cfg.scale[i]);
            n_d0.val[i]   = v;
            n_d0.neg[i]   = r4_v[i][V2W-1];
            n_d0.early[i] = (num >= thr);
            n_d0.zero[i]  = n_d0.dm && (i_cfg.scale[i] == '0);
            n_d0.rem[i]   = num[QTW +: SW];
            n_d0.low[i]   = num[QTW-1:0];
        end
    end

    always_comb begin
        logic signed [OW-1:0] qs;
        n_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            qs = $signed({{(OW-QTW){1'b0}}, r_d[NDIV].quo[i]});
            if (r_d[NDIV].dm) begin
                if (r_d[NDIV].zero[i]) begin
                    w_fv[i] = '0;
                end else if (r_d[NDIV].early[i]) begin
                    w_fv[i] = r_d[NDIV].neg[i] ? -DIV_OVF : DIV_OVF;
                end else begin
                    w_fv[i] = r_d[NDIV].neg[i] ? -qs : qs;
                end
            end else begin
                w_fv[i] = r_d[NDIV].val[i];
            end
            if (w_fv[i] > SAT_MAX) begin
                n_res[i] = DW'(SAT_MAX);
                n_sat = 1'b1;
            end else if (w_fv[i] < SAT_MIN) begin
                n_res[i] = DW'(SAT_MIN);
                n_sat = 1'b1;
            end else begin
                n_res[i] = DW'(w_fv[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k <= NDIV; k++) begin
                r_d[k].vld <= 1'b0;
            end
        end else if (w_en) begin
            r1_vld    <= i_item_vld;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r_d[0]    <= n_d0;
            for (int k = 1; k <= NDIV; k++) begin
                r_d[k] <= div_step(r_d[k-1], i_cfg);
            end
            r_out_vld <= r_d[NDIV].vld;
        end
        if (w_en) begin
            // first cross product
            r1_mode <= i_item.mode;
            r1_v    <= w_vin;
            r1_p[0] <= w_qa[1] * w_vin[2];
            r1_p[1] <= w_qa[2] * w_vin[1];
            r1_p[2] <= w_qa[2] * w_vin[0];
            r1_p[3] <= w_qa[0] * w_vin[2];
            r1_p[4] <= w_qa[0] * w_vin[1];
            r1_p[5] <= w_qa[1] * w_vin[0];
            // doubled cross term, round half up
            r2_mode <= r1_mode;
            r2_v    <= r1_v;
            for (int i = 0; i < 3; i++) begin
                r2_t[i] <= TW'((CPW'(r1_p[2*i]) - CPW'(r1_p[2*i+1]) + CPW'(4096)) >>> 13);
            end
            // second cross product and scalar term
            r3_mode  <= r2_mode;
            r3_v     <= r2_v;
            r3_m[0]  <= w_qc[1] * r2_t[2];
            r3_m[1]  <= w_qc[2] * r2_t[1];
            r3_m[2]  <= w_qc[2] * r2_t[0];
            r3_m[3]  <= w_qc[0] * r2_t[2];
            r3_m[4]  <= w_qc[0] * r2_t[1];
            r3_m[5]  <= w_qc[1] * r2_t[0];
            for (int i = 0; i < 3; i++) begin
                r3_wt[i] <= w_w * r2_t[i];
            end
            // rotated vector
            r4_mode <= r3_mode;
            for (int i = 0; i < 3; i++) begin
                r4_v[i] <= V2W'(r3_v[i]) + V2W'(RW'((UW'(r3_wt[i]) + UW'(r3_m[2*i])
                           - UW'(r3_m[2*i+1]) + UW'(8192)) >>> 14));
            end
            r_res  <= n_res;
            r_sat  <= n_sat;
            r_zerr <= r_d[NDIV].dm && (r_d[NDIV].zero != 3'b000);
        end
    end

    assign o_valid            = r_out_vld;
    assign o_res_x            = r_res[0];
    assign o_res_y            = r_res[1];
    assign o_res_z            = r_res[2];
    assign o_saturated        = r_sat;
    assign o_zero_scale_error = r_zerr;

endmodule

`default_nettype wire

### src/quaternion_vector_transform_unit.sv
// ----------------------------------------------------------------------------
// Quaternion vector transform unit
// Scales, rotates by a configured quaternion and translates 3-vectors, or
// applies the inverse. One request is accepted per clock when the result side
// is not stalled. A request passes the front-end register, the queue, the
// four-stage rotation pipeline and the 24-stage pipelined scale divider.
// A four-entry request queue separates the accepting front end from the
// arithmetic back end. Configuration writes are taken at any time, one per
// cycle, but are meant for idle periods only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quaternion_vector_transform_unit_assert.svh"

module quaternion_vector_transform_unit import qvt_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CW_IDX-1:0]    i_cfg_index,
    input  wire logic [63:0]          i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [2:0]           i_req_type,
    input  wire logic signed [DW-1:0] i_vec_x,
    input  wire logic signed [DW-1:0] i_vec_y,
    input  wire logic signed [DW-1:0] i_vec_z,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic signed [DW-1:0]      o_res_x,
    output logic signed [DW-1:0]      o_res_y,
    output logic signed [DW-1:0]      o_res_z,
    output logic                      o_saturated,
    output logic                      o_zero_scale_error
);

    t_cfg       r_cfg;
    t_qstat     q_stat;
    t_item      q_in;
    t_item      q_out;
    logic       q_push;
    logic       q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot   <= 64'h4000_0000_0000_0000;
            r_cfg.scale <= {3{16'h0100}};
            r_cfg.tr    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_ROT: r_cfg.rot      <= i_cfg_data;
                REG_SX:  r_cfg.scale[0] <= i_cfg_data[SW-1:0];
                REG_SY:  r_cfg.scale[1] <= i_cfg_data[SW-1:0];
                REG_SZ:  r_cfg.scale[2] <= i_cfg_data[SW-1:0];
                REG_TX:  r_cfg.tr[0]    <= i_cfg_data[DW-1:0];
                REG_TY:  r_cfg.tr[1]    <= i_cfg_data[DW-1:0];
                REG_TZ:  r_cfg.tr[2]    <= i_cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    qvt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_vec_x    (i_vec_x),
        .i_vec_y    (i_vec_y),
        .i_vec_z    (i_vec_z),
        .i_cfg      (r_cfg),
        .i_qstat    (q_stat),
        .o_push     (q_push),
        .o_item     (q_in)
    );

    qvt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_stat  (q_stat)
    );

    qvt_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_item             (q_out),
        .i_item_vld         (!q_stat.empty),
        .o_pop              (q_pop),
        .i_cfg              (r_cfg),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_res_x            (o_res_x),
        .o_res_y            (o_res_y),
        .o_res_z            (o_res_z),
        .o_saturated        (o_saturated),
        .o_zero_scale_error (o_zero_scale_error)
    );

    `QVT_ASSERT_IMP(a_push_not_full, q_push, !q_stat.full)
    `QVT_ASSERT_IMP(a_pop_not_empty, q_pop, !q_stat.empty)
    `QVT_ASSERT_IMP(a_stall_means_full, o_stall, q_stat.full)
    `QVT_ASSERT_NXT(a_full_push_blocked, q_stat.full && !q_pop, !q_stat.empty)

endmodule

`default_nettype wire

### test/tb_quaternion_vector_transform_unit.sv
// ----------------------------------------------------------------------------
// Quaternion vector transform unit testbench
// Drives requests through the scale-rotate-translate unit and checks every
// result against a table value or a bit-exact predictor. A directed table
// comes first, then random requests under a series of register settings,
// extremes included, random request gaps and result stall in most settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quaternion_vector_transform_unit;
    import qvt_pkg::*;

    localparam logic [2:0] REQ_DIR  = 3'b000;
    localparam logic [2:0] REQ_POS  = 3'b001;
    localparam logic [2:0] REQ_SKIP = 3'b010;
    localparam logic [2:0] REQ_INV  = 3'b100;
    localparam logic [23:0] MAXV = 24'h7FFFFF;
    localparam logic [23:0] MINV = 24'h800000;
    localparam int SETTINGS_N = 10;
    localparam int ITEMS_PER_SETTING = 183;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic               sat;
        logic               zerr;
    } vec_result_t;

    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  idx;
        logic [63:0] data;
        logic [2:0]  req;
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
        logic        typed;
        vec_result_t res;
    } dir_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CW_IDX-1:0]    i_cfg_index = '0;
    logic [63:0]          i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [2:0]           i_req_type = '0;
    logic signed [DW-1:0] i_vec_x = '0;
    logic signed [DW-1:0] i_vec_y = '0;
    logic signed [DW-1:0] i_vec_z = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic signed [DW-1:0] o_res_x;
    logic signed [DW-1:0] o_res_y;
    logic signed [DW-1:0] o_res_z;
    logic                 o_saturated;
    logic                 o_zero_scale_error;

    logic [63:0]        rot_cfg;
    logic [15:0]        scale_cfg [3];
    logic signed [23:0] trans_cfg [3];

    vec_result_t pending_results [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          gap_pct = 14;
    int          stall_pct = 73;

    quaternion_vector_transform_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_req_type         (i_req_type),
        .i_vec_x            (i_vec_x),
        .i_vec_y            (i_vec_y),
        .i_vec_z            (i_vec_z),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_res_x            (o_res_x),
        .o_res_y            (o_res_y),
        .o_res_z            (o_res_z),
        .o_saturated        (o_saturated),
        .o_zero_scale_error (o_zero_scale_error)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic vec_result_t transform_vec(logic [2:0] req, logic signed [23:0] ix,
                                                  logic signed [23:0] iy, logic signed [23:0] iz);
        longint v [3];
        longint q [3];
        longint c [3];
        longint t [3];
        longint w;
        longint unsigned mag;
        longint unsigned quo;
        logic zero_div [3];
        vec_result_t r;
        int j;
        int k;
        r = '0;
        v[0] = ix;
        v[1] = iy;
        v[2] = iz;
        w = longint'($signed(rot_cfg[63:48]));
        for (int i = 0; i < 3; i++) begin
            q[i] = longint'($signed(rot_cfg[16*i +: 16]));
            zero_div[i] = 1'b0;
        end
        if (!req[2]) begin
            if (!req[1])
                for (int i = 0; i < 3; i++) v[i] = (v[i] * longint'(scale_cfg[i]) + 128) >>> 8;
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (req[0]) v[i] = v[i] - longint'(trans_cfg[i]);
                q[i] = -q[i];
            end
        end
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            c[i] = q[j] * v[k] - q[k] * v[j];
            t[i] = (c[i] + 4096) >>> 13;
        end
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            c[i] = q[j] * t[k] - q[k] * t[j];
        end
        for (int i = 0; i < 3; i++) begin
            v[i] = v[i] + ((w * t[i] + c[i] + 8192) >>> 14);
            if (!req[2] && req[0]) v[i] = v[i] + longint'(trans_cfg[i]);
            if (req[2] && !req[1]) begin
                if (scale_cfg[i] == 16'd0) begin
                    zero_div[i] = 1'b1;
                    r.zerr = 1'b1;
                    v[i] = 0;
                end else begin
                    mag = (v[i] < 0) ? longint'(-v[i]) : v[i];
                    quo = (mag * 256 + scale_cfg[i] / 2) / scale_cfg[i];
                    v[i] = (v[i] < 0) ? -longint'(quo) : longint'(quo);
                end
            end
            if (!zero_div[i]) begin
                if (v[i] > 8388607) begin
                    v[i] = 8388607;
                    r.sat = 1'b1;
                end else if (v[i] < -8388608) begin
                    v[i] = -8388608;
                    r.sat = 1'b1;
                end
            end
        end
        r.x = v[0][23:0];
        r.y = v[1][23:0];
        r.z = v[2][23:0];
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        if (!i_cfg_valid) begin
            i_valid <= 1'b0;
            wait_drained();
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_ROT: rot_cfg = data;
            REG_SX:  scale_cfg[0] = data[15:0];
            REG_SY:  scale_cfg[1] = data[15:0];
            REG_SZ:  scale_cfg[2] = data[15:0];
            REG_TX:  trans_cfg[0] = data[23:0];
            REG_TY:  trans_cfg[1] = data[23:0];
            REG_TZ:  trans_cfg[2] = data[23:0];
            default: ;
        endcase
    endtask

    task automatic send_request(logic [2:0] req, logic [23:0] x, logic [23:0] y,
                                logic [23:0] z, logic typed, vec_result_t typed_res);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_vec_x    <= x;
        i_vec_y    <= y;
        i_vec_z    <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(typed ? typed_res : transform_vec(req, x, y, z));
    endtask

    function automatic logic [23:0] rand_coord();
        if ($urandom_range(0, 1)) return 24'($urandom);
        return 24'($signed($urandom_range(0, 65535)) - 32768);
    endfunction

    function automatic logic [63:0] rand_rotation();
        logic [15:0] wc;
        logic [47:0] xyz;
        if ($urandom_range(0, 2) == 0) return {$urandom, $urandom};
        wc = 16'($signed($urandom_range(0, 32768)) - 16384);
        for (int i = 0; i < 3; i++)
            xyz[16*i +: 16] = 16'($signed($urandom_range(0, 16384)) - 8192);
        return {wc, xyz};
    endfunction

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        vec_result_t got;
        vec_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_res_x, o_res_y, o_res_z, o_saturated, o_zero_scale_error};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.x !== want.x)
                    $display("%0t: res_x expected %h got %h", $time, want.x, got.x);
                if (got.y !== want.y)
                    $display("%0t: res_y expected %h got %h", $time, want.y, got.y);
                if (got.z !== want.z)
                    $display("%0t: res_z expected %h got %h", $time, want.z, got.z);
                if (got.sat !== want.sat)
                    $display("%0t: saturated expected %b got %b", $time, want.sat, got.sat);
                if (got.zerr !== want.zerr)
                    $display("%0t: zero_scale_error expected %b got %b",
                             $time, want.zerr, got.zerr);
                if (got !== want) fail_count++;
            end
        end
    end

    dir_row_t dir_rows [27] = '{
        '{1'b0, REG_ROT, 64'd0, REQ_DIR, MAXV, MINV, 24'd1, 1'b1,
          '{MAXV, MINV, 24'd1, 1'b0, 1'b0}},
        '{1'b0, REG_ROT, 64'd0, REQ_POS, MINV, MAXV, 24'hFFFFFF, 1'b1,
          '{MINV, MAXV, 24'hFFFFFF, 1'b0, 1'b0}},
        '{1'b0, REG_ROT, 64'd0, REQ_INV | REQ_POS, 24'h123456, 24'h000100, MINV, 1'b1,
          '{24'h123456, 24'h000100, MINV, 1'b0, 1'b0}},
        '{1'b0, REG_ROT, 64'd0, REQ_INV | REQ_SKIP, MAXV, 24'd0, MINV, 1'b1,
          '{MAXV, 24'd0, MINV, 1'b0, 1'b0}},
        '{1'b0, REG_ROT, 64'd0, REQ_SKIP | REQ_POS, 24'hABCDEF, 24'h555555, 24'hAAAAAA, 1'b1,
          '{24'hABCDEF, 24'h555555, 24'hAAAAAA, 1'b0, 1'b0}},
        '{1'b0, REG_ROT, 64'd0, REQ_INV | REQ_SKIP | REQ_POS, 24'd0, 24'd0, 24'd0, 1'b1,
          '{24'd0, 24'd0, 24'd0, 1'b0, 1'b0}},
        '{1'b0, REG_ROT, 64'd0, REQ_INV, MINV, 24'h000080, MAXV, 1'b1,
          '{MINV, 24'h000080, MAXV, 1'b0, 1'b0}},
        '{1'b1, REG_SX, 64'd0, REQ_DIR, 24'd0, 24'd0, 24'd0, 1'b0, '0},
        '{1'b0, REG_ROT, 64'd0, REQ_INV, 24'h000100, 24'h000200, MINV, 1'b1,
          '{24'd0, 24'h000200, MINV, 1'b0, 1'b1}},
        '{1'b0, REG_ROT, 64'd0, REQ_DIR, MAXV, 24'h000300, 24'd7, 1'b1,
          '{24'd0, 24'h000300, 24'd7, 1'b0, 1'b0}},
        '{1'b0, REG_ROT, 64'd0, REQ_INV | REQ_SKIP, MAXV, MAXV, MAXV, 1'b1,
          '{MAXV, MAXV, MAXV, 1'b0, 1'b0}},
        '{1'b1, REG_SX, 64'd256, REQ_DIR, 24'd0, 24'd0, 24'd0, 1'b0, '0},
        '{1'b1, REG_TX, 64'(MAXV), REQ_DIR, 24'd0, 24'd0, 24'd0, 1'b0, '0},
        '{1'b0, REG_ROT, 64'd0, REQ_POS, MAXV, 24'd1, 24'd2, 1'b1,
          '{MAXV, 24'd1, 24'd2, 1'b1, 1'b0}},
        '{1'b0, REG_ROT, 64'd0, REQ_INV | REQ_POS, MINV, 24'd1, 24'd2, 1'b1,
          '{MINV, 24'd1, 24'd2, 1'b1, 1'b0}},
        '{1'b0, REG_ROT, 64'd0, REQ_DIR, MAXV, 24'd1, 24'd2, 1'b1,
          '{MAXV, 24'd1, 24'd2, 1'b0, 1'b0}},
        '{1'b1, REG_TX, 64'd0, REQ_DIR, 24'd0, 24'd0, 24'd0, 1'b0, '0},
        '{1'b1, REG_ROT, 64'h7FFF_7FFF_7FFF_7FFF, REQ_DIR, 24'd0, 24'd0, 24'd0, 1'b0, '0},
        '{1'b1, REG_SY, 64'hFFFF, REQ_DIR, 24'd0, 24'd0, 24'd0, 1'b0, '0},
        '{1'b0, REG_ROT, 64'd0, REQ_POS, MAXV, MAXV, MAXV, 1'b0, '0},
        '{1'b0, REG_ROT, 64'd0, REQ_INV, MINV, 24'h000400, 24'hFFF000, 1'b0, '0},
        '{1'b0, REG_ROT, 64'd0, REQ_SKIP, 24'h000100, 24'hFFFF00, 24'h000001, 1'b0, '0},
        '{1'b1, REG_ROT, 64'h8000_8000_8000_8000, REQ_DIR, 24'd0, 24'd0, 24'd0, 1'b0, '0},
        '{1'b1, REG_SZ, 64'd0, REQ_DIR, 24'd0, 24'd0, 24'd0, 1'b0, '0},
        '{1'b0, REG_ROT, 64'd0, REQ_INV, 24'h000010, 24'hFFFFF0, 24'h000300, 1'b0, '0},
        '{1'b0, REG_ROT, 64'd0, REQ_INV | REQ_POS, MINV, MAXV, MINV, 1'b0, '0},
        '{1'b0, REG_ROT, 64'd0, REQ_DIR, 24'h000123, 24'hFFFEDC, MAXV, 1'b0, '0}
    };

    initial begin
        logic [63:0] rot_val;
        logic [15:0] sc_val [3];
        logic [23:0] tr_val [3];
        rot_cfg = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 3; i++) begin
            scale_cfg[i] = 16'd256;
            trans_cfg[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg) begin
                write_reg(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                if (i_cfg_valid) i_cfg_valid <= 1'b0;
                send_request(dir_rows[r].req, dir_rows[r].x, dir_rows[r].y, dir_rows[r].z,
                             dir_rows[r].typed, dir_rows[r].res);
            end
        end

        for (int s = 0; s < SETTINGS_N; s++) begin
            case (s)
                0: begin
                    rot_val = 64'h4000_0000_0000_0000;
                    sc_val = '{16'd256, 16'd256, 16'd256};
                    tr_val = '{24'd0, 24'd0, 24'd0};
                end
                2: begin
                    rot_val = 64'h7FFF_7FFF_7FFF_7FFF;
                    sc_val = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
                    tr_val = '{MAXV, MAXV, MAXV};
                end
                3: begin
                    rot_val = 64'h8000_8000_8000_8000;
                    sc_val = '{16'd0, 16'd0, 16'd0};
                    tr_val = '{MINV, MINV, MINV};
                end
                default: begin
                    rot_val = rand_rotation();
                    for (int i = 0; i < 3; i++) begin
                        sc_val[i] = ($urandom_range(0, 5) == 0) ? 16'd0 :
                                    ($urandom_range(0, 1) ? 16'($urandom) :
                                     16'($urandom_range(64, 1024)));
                        tr_val[i] = rand_coord();
                    end
                end
            endcase
            if (s < 4) begin
                gap_pct = 14;
                stall_pct = 73;
            end else if (s < 7) begin
                gap_pct = 73;
                stall_pct = 14;
            end else begin
                gap_pct = 0;
                stall_pct = 0;
            end
            write_reg(REG_ROT, rot_val);
            write_reg(REG_SX, 64'(sc_val[0]));
            write_reg(REG_SY, 64'(sc_val[1]));
            write_reg(REG_SZ, 64'(sc_val[2]));
            write_reg(REG_TX, 64'(tr_val[0]));
            write_reg(REG_TY, 64'(tr_val[1]));
            write_reg(REG_TZ, 64'(tr_val[2]));
            i_cfg_valid <= 1'b0;
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                if (s == 5 && n == 90) begin
                    i_valid <= 1'b0;
                    wait_drained();
                end
                send_request(3'($urandom_range(0, 7)), rand_coord(), rand_coord(),
                             rand_coord(), 1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
